// File: src/rng_pkg.sv
// ----------------------------------------------------------------------------
// rng_pkg: shared constants for the RMS noise gate
// Field widths, register indexes and reset values used by the gate and its
// channel interfaces.
// ----------------------------------------------------------------------------
package rng_pkg;

    localparam int WINDOW_DEF      = 512;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int ENERGY_W   = 55;
    localparam int GAIN_W     = 17;
    localparam int STEP_W     = 17;
    localparam int MAKEUP_W   = 17;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 55;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [GAIN_W-1:0]   GAIN_UNITY = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0]   GAIN_ZERO  = '0;

    localparam int OUT_SHIFT = 28;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = CFG_IDX_W'(3);

    localparam logic [ENERGY_W-1:0] THRESHOLD_RST = '0;
    localparam logic [STEP_W-1:0]   ATTACK_RST    = STEP_W'(22);
    localparam logic [STEP_W-1:0]   RELEASE_RST   = STEP_W'(14);
    localparam logic [MAKEUP_W-1:0] MAKEUP_RST    = MAKEUP_W'(4096);

endpackage

// File: src/rng_intf.sv
// ----------------------------------------------------------------------------
// rng_intf: request channels of the RMS noise gate
// Sample input, gated result output and configuration write channels.
// ----------------------------------------------------------------------------
interface rng_in_if #(
    parameter int SAMPLE_BITS = rng_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface rng_out_if #(
    parameter int SAMPLE_BITS = rng_pkg::SAMPLE_BITS_DEF
) ();
    import rng_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [GAIN_W-1:0]             gate_gain;
    logic [ENERGY_W-1:0]           window_energy;

    modport source (output valid, output sample_out, output gate_gain,
                    output window_energy, input ready);
    modport sink   (input valid, input sample_out, input gate_gain,
                    input window_energy, output ready);
endinterface

interface rng_cfg_if ();
    import rng_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/rms_noise_gate_unit.sv
// ----------------------------------------------------------------------------
// rms_noise_gate_unit: noise gate with a sum-of-squares level detector
// The gate keeps the last WINDOW samples in a memory, updates their energy
// per sample and ramps its gain up or down against a threshold energy.
//
// Channels: din carries one sample per request, dout returns one result per
// sample (gated sample, gate gain, window energy), cfg writes one of four
// registers by index; unknown indexes are ignored and cfg is always ready.
// The sequencer walks each sample through a window memory read, the squaring
// multipliers, the energy update, the gain update and two scaling multipliers
// before it takes the next one. A stalled receiver holds the finished result
// in the output register; the next sample is still taken and waits in its
// last step until dout drains.
// Reset clears the energy, the gain, the write position and the registers to
// their defaults. The window memory is not swept: slots not yet written in
// the first lap read as zero.
// ----------------------------------------------------------------------------
module rms_noise_gate_unit #(
    parameter int WINDOW      = rng_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = rng_pkg::SAMPLE_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    rng_in_if.sink     din,
    rng_out_if.source  dout,
    rng_cfg_if.sink    cfg
);
    import rng_pkg::*;

    localparam int AW     = $clog2(WINDOW);
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int ACC_W  = SQ_W + AW;
    localparam int SUM_W  = (ACC_W > ENERGY_W) ? ACC_W : ENERGY_W + 1;
    localparam int GM_W   = GAIN_W + MAKEUP_W;
    localparam int PROD_W = SAMPLE_BITS + GM_W;
    localparam int HI_W   = PROD_W + 1;
    localparam int RES_W  = HI_W - (OUT_SHIFT - 1);

    localparam logic [AW:0]             WINDOW_V  = (AW + 1)'(WINDOW);
    localparam logic [SUM_W-1:0]        SUM_LIM   = SUM_W'(ENERGY_MAX);
    localparam logic [HI_W-1:0]         ROUND_ADD = HI_W'(1) << (OUT_SHIFT - 2);
    localparam logic [RES_W-1:0]        RES_LIM   = RES_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0]  POS_MAX   = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ENERGY,
        S_GAIN,
        S_MIX,
        S_SCALE,
        S_OUT
    } state_t;

    state_t                  state_reg;
    logic [AW-1:0]           pos_reg;
    logic                    lap_done_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic [ENERGY_W-1:0]     energy_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SAMPLE_BITS-1:0]  mag_reg;
    logic [SQ_W-1:0]         old_sq_reg;
    logic [SQ_W-1:0]         new_sq_reg;
    logic [GM_W-1:0]         gm_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  out_sample_reg;
    logic [GAIN_W-1:0]       out_gain_reg;
    logic [ENERGY_W-1:0]     out_energy_reg;
    logic [ENERGY_W-1:0]     threshold_reg;
    logic [STEP_W-1:0]       attack_reg;
    logic [STEP_W-1:0]       release_reg;
    logic [MAKEUP_W-1:0]     makeup_reg;

    logic [SAMPLE_BITS-1:0]  win_mem [WINDOW];
    logic [SAMPLE_BITS-1:0]  rd_data_reg;

    logic [AW:0]             pos_inc;
    logic [AW-1:0]           pos_wrap;
    logic                    in_take;
    logic [SAMPLE_BITS-1:0]  new_mag;
    logic [SAMPLE_BITS-1:0]  old_mag;
    logic [ENERGY_W-1:0]     energy_sat;
    logic [GAIN_W-1:0]       gain_dn;
    logic [GAIN_W:0]         gain_up_sum;
    logic [GAIN_W-1:0]       gain_up;
    logic [HI_W-1:0]         hi;
    logic [RES_W-1:0]        res;
    logic [RES_W-1:0]        res_cl;
    logic [SAMPLE_BITS-1:0]  y;
    logic                    out_load;

    function automatic logic [SAMPLE_BITS-1:0] abs_val(input logic [SAMPLE_BITS-1:0] s);
        abs_val = s[SAMPLE_BITS-1] ? (~s + SAMPLE_BITS'(1)) : s;
    endfunction

    assign din.ready = (state_reg == S_IDLE);
    assign in_take   = din.valid && din.ready;
    assign cfg.ready = 1'b1;

    assign pos_inc  = {1'b0, pos_reg} + (AW + 1)'(1);
    assign pos_wrap = (pos_inc >= WINDOW_V) ? '0 : pos_inc[AW-1:0];

    assign new_mag = abs_val(sample_reg);
    assign old_mag = lap_done_reg ? abs_val(rd_data_reg) : '0;

    assign energy_sat  = (sum_reg > SUM_LIM) ? ENERGY_MAX : sum_reg[ENERGY_W-1:0];
    assign gain_dn     = (release_reg >= gain_reg) ? GAIN_ZERO : gain_reg - release_reg;
    assign gain_up_sum = {1'b0, gain_reg} + {1'b0, attack_reg};
    assign gain_up     = (gain_up_sum > {1'b0, GAIN_UNITY}) ? GAIN_UNITY
                                                            : gain_up_sum[GAIN_W-1:0];

    assign hi     = ({1'b0, prod_reg} >> 1) + ROUND_ADD + HI_W'(prod_reg[0]);
    assign res    = hi[HI_W-1:OUT_SHIFT-1];
    assign res_cl = (res > RES_LIM) ? RES_LIM : res;

    always_comb
    begin
        if (sample_reg[SAMPLE_BITS-1])
        begin
            y = ~res_cl[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1);
        end
        else if (res_cl > RES_W'(POS_MAX))
        begin
            y = POS_MAX;
        end
        else
        begin
            y = res_cl[SAMPLE_BITS-1:0];
        end
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || dout.ready);

    assign dout.valid         = out_valid_reg;
    assign dout.sample_out    = out_sample_reg;
    assign dout.gate_gain     = out_gain_reg;
    assign dout.window_energy = out_energy_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SQUARE)
        begin
            win_mem[pos_reg] <= sample_reg;
        end
        rd_data_reg <= win_mem[pos_wrap];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            lap_done_reg   <= 1'b0;
            sum_reg        <= '0;
            gain_reg       <= GAIN_ZERO;
            energy_reg     <= '0;
            sample_reg     <= '0;
            mag_reg        <= '0;
            old_sq_reg     <= '0;
            new_sq_reg     <= '0;
            gm_reg         <= '0;
            prod_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_gain_reg   <= GAIN_ZERO;
            out_energy_reg <= '0;
            threshold_reg  <= THRESHOLD_RST;
            attack_reg     <= ATTACK_RST;
            release_reg    <= RELEASE_RST;
            makeup_reg     <= MAKEUP_RST;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_THRESHOLD: threshold_reg <= cfg.data[ENERGY_W-1:0];
                    REG_ATTACK:    attack_reg    <= cfg.data[STEP_W-1:0];
                    REG_RELEASE:   release_reg   <= cfg.data[STEP_W-1:0];
                    REG_MAKEUP:    makeup_reg    <= cfg.data[MAKEUP_W-1:0];
                    default:       ;
                endcase
            end

            if (out_valid_reg && dout.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        sample_reg <= din.sample_in;
                        pos_reg    <= pos_wrap;
                        state_reg  <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    mag_reg      <= new_mag;
                    new_sq_reg   <= SQ_W'(new_mag) * SQ_W'(new_mag);
                    old_sq_reg   <= SQ_W'(old_mag) * SQ_W'(old_mag);
                    lap_done_reg <= lap_done_reg || (pos_reg == '0);
                    state_reg    <= S_ENERGY;
                end
                S_ENERGY:
                begin
                    sum_reg   <= sum_reg + SUM_W'(new_sq_reg) - SUM_W'(old_sq_reg);
                    state_reg <= S_GAIN;
                end
                S_GAIN:
                begin
                    energy_reg <= energy_sat;
                    gain_reg   <= (energy_sat < threshold_reg) ? gain_dn : gain_up;
                    state_reg  <= S_MIX;
                end
                S_MIX:
                begin
                    gm_reg    <= GM_W'(gain_reg) * GM_W'(makeup_reg);
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    prod_reg  <= PROD_W'(mag_reg) * PROD_W'(gm_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= y;
                        out_gain_reg   <= gain_reg;
                        out_energy_reg <= energy_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !din.ready)
        else $error("Input request accepted while a sample is in progress.");

    a_gain_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GAIN) |=> (gain_reg <= GAIN_UNITY))
        else $error("Gate gain exceeded unity.");

    a_lap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        lap_done_reg |=> lap_done_reg)
        else $error("Window lap flag cleared without reset.");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pos_reg} < WINDOW_V))
        else $error("Write position left the window.");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (dout.valid && (state_reg == S_IDLE)))
        else $error("Result load did not present a result.");

    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_valid_reg && !dout.ready) |=> (state_reg == S_OUT))
        else $error("Result overwritten while the receiver stalls.");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for rms_noise_gate_unit
// Drives audio samples and register writes through the request channels,
// keeps its own model of the window energy, the gate gain and the output
// scaling, and checks every result in order against it or a typed row.
// A short directed table comes first, then random phases with new settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rng_pkg::*;

    localparam int RANDOM_ITEMS   = 1400;
    localparam int PHASE_ITEMS    = 200;
    localparam int QUIET_TAIL     = 200;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PTR_W          = $clog2(WINDOW_DEF);

    typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

    localparam sample_t POS_FULL = sample_t'(8388607);
    localparam sample_t NEG_FULL = sample_t'(-8388608);

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = REG_MAKEUP + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = '1;

    localparam logic [ENERGY_W-1:0] SQ_POS = (55'd1 << 46) - (55'd1 << 24) + 55'd1;
    localparam logic [ENERGY_W-1:0] SQ_NEG = 55'd1 << 46;
    localparam logic [ENERGY_W-1:0] THR_EQ = 2 * SQ_POS + 2 * SQ_NEG + 55'd10001;

    typedef struct packed {
        sample_t             sample_out;
        logic [GAIN_W-1:0]   gate_gain;
        logic [ENERGY_W-1:0] window_energy;
    } gate_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        gate_result_t          want;
    } directed_row_t;

    localparam int ROW_COUNT = 29;

    localparam directed_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        '{ROW_SAMPLE, '0, CFG_DATA_W'(0), 1'b1, '{sample_t'(0), 17'd22, 55'd0}},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(8388607), 1'b1, '{sample_t'(5632), 17'd44, SQ_POS}},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(-8388608), 1'b1,
          '{sample_t'(-8448), 17'd66, SQ_POS + SQ_NEG}},
        '{ROW_WRITE, REG_ATTACK, CFG_DATA_W'(65536), 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(1), 1'b1,
          '{sample_t'(1), 17'd65536, SQ_POS + SQ_NEG + 55'd1}},
        '{ROW_WRITE, REG_MAKEUP, CFG_DATA_W'(131071), 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(8388607), 1'b1,
          '{POS_FULL, 17'd65536, 2 * SQ_POS + SQ_NEG + 55'd1}},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(-8388608), 1'b1,
          '{NEG_FULL, 17'd65536, 2 * SQ_POS + 2 * SQ_NEG + 55'd1}},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(100), 1'b0, '0},
        '{ROW_WRITE, REG_THRESHOLD, CFG_DATA_W'(THR_EQ), 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(0), 1'b0, '0},
        '{ROW_WRITE, REG_THRESHOLD, CFG_DATA_W'(THR_EQ + 55'd1), 1'b0, '0},
        '{ROW_WRITE, REG_RELEASE, CFG_DATA_W'(100000), 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(0), 1'b1, '{sample_t'(0), 17'd0, THR_EQ}},
        '{ROW_WRITE, REG_RELEASE, CFG_DATA_W'(14), 1'b0, '0},
        '{ROW_WRITE, REG_THRESHOLD, CFG_DATA_W'(ENERGY_MAX), 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(5), 1'b0, '0},
        '{ROW_WRITE, REG_THRESHOLD, CFG_DATA_W'(0), 1'b0, '0},
        '{ROW_WRITE, REG_MAKEUP, CFG_DATA_W'(1), 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(2048), 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(-2048), 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(2047), 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(6144), 1'b0, '0},
        '{ROW_WRITE, REG_UNMAPPED_FIRST, '1, 1'b0, '0},
        '{ROW_WRITE, REG_UNMAPPED_LAST, '1, 1'b0, '0},
        '{ROW_WRITE, REG_ATTACK, {{(CFG_DATA_W-STEP_W){1'b1}}, STEP_W'(30)}, 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(3), 1'b0, '0},
        '{ROW_WRITE, REG_MAKEUP, CFG_DATA_W'(0), 1'b0, '0},
        '{ROW_SAMPLE, '0, CFG_DATA_W'(8388607), 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic idling_on;
    int   mismatches;
    int   quiet_cycles;

    rng_in_if  din ();
    rng_out_if dout ();
    rng_cfg_if cfg ();

    rms_noise_gate_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout),
        .cfg   (cfg)
    );

    logic [ENERGY_W-1:0] energy_thr;
    logic [STEP_W-1:0]   attack_inc;
    logic [STEP_W-1:0]   release_dec;
    logic [MAKEUP_W-1:0] makeup_lin;
    sample_t             window_mem [WINDOW_DEF];
    logic [PTR_W-1:0]    slot_ptr;
    logic [GAIN_W-1:0]   gain_now;

    gate_result_t gated_results_due [$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic compute_gated_result(input sample_t s, output gate_result_t r);
        longint unsigned sum;
        longint unsigned m;
        longint unsigned scaled;
        longint unsigned rounded;
        longint v;
        logic [GAIN_W:0] raised;
        if (slot_ptr == PTR_W'(WINDOW_DEF - 1))
            slot_ptr = '0;
        else
            slot_ptr = slot_ptr + 1'b1;
        window_mem[slot_ptr] = s;

        sum = 0;
        for (int i = 0; i < WINDOW_DEF; i++)
        begin
            v = window_mem[i];
            m = (v < 0) ? longint'(-v) : longint'(v);
            sum = sum + m * m;
            if (sum > longint'(ENERGY_MAX))
                sum = longint'(ENERGY_MAX);
        end

        if (sum < longint'(energy_thr))
        begin
            if (release_dec >= gain_now)
                gain_now = GAIN_ZERO;
            else
                gain_now = gain_now - release_dec;
        end
        else
        begin
            raised = gain_now + attack_inc;
            gain_now = (raised > GAIN_UNITY) ? GAIN_UNITY : GAIN_W'(raised);
        end

        v = s;
        m = (v < 0) ? longint'(-v) : longint'(v);
        scaled = m * longint'(gain_now) * longint'(makeup_lin);
        rounded = ((scaled >> 1) + (64'd1 << (OUT_SHIFT - 2)) + scaled[0]) >> (OUT_SHIFT - 1);
        if (rounded > 64'd8388608)
            rounded = 64'd8388608;
        if (v < 0)
            r.sample_out = sample_t'(-longint'(rounded));
        else if (rounded > 64'd8388607)
            r.sample_out = POS_FULL;
        else
            r.sample_out = sample_t'(rounded);
        r.gate_gain = gain_now;
        r.window_energy = sum[ENERGY_W-1:0];
    endtask

    task automatic send_sample(input sample_t s, input logic typed, input gate_result_t want);
        gate_result_t predicted;
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            din.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        din.valid     <= 1'b1;
        din.sample_in <= s;
        do @(posedge clk); while (!din.ready);
        compute_gated_result(s, predicted);
        gated_results_due.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        case (index)
            REG_THRESHOLD: energy_thr  = data[ENERGY_W-1:0];
            REG_ATTACK:    attack_inc  = data[STEP_W-1:0];
            REG_RELEASE:   release_dec = data[STEP_W-1:0];
            REG_MAKEUP:    makeup_lin  = data[MAKEUP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic finish_requests();
        @(negedge clk);
        din.valid <= 1'b0;
        while (gated_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_step();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return CFG_DATA_W'(1);
            2: return CFG_DATA_W'($urandom_range(1, 2000));
            3: return CFG_DATA_W'(65535);
            4: return CFG_DATA_W'(65536);
            5: return CFG_DATA_W'(131071);
            default: return CFG_DATA_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return CFG_DATA_W'(ENERGY_MAX);
            2: return CFG_DATA_W'({$urandom, $urandom});
            default: return CFG_DATA_W'(64'd1 << $urandom_range(25, 54));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_makeup();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return CFG_DATA_W'(4096);
            2: return CFG_DATA_W'(131071);
            3: return CFG_DATA_W'($urandom_range(0, 8192));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    initial
    begin : sink_side
        int stall_left;
        stall_left = 0;
        dout.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                dout.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                dout.ready <= 1'b0;
            end
            else
                dout.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        gate_result_t want;
        if (din.valid && din.ready || dout.valid && dout.ready || cfg.valid && cfg.ready)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && dout.valid && dout.ready)
        begin
            if (gated_results_due.size() == 0)
            begin
                $display("%0t: result with no request waiting: sample_out %0d gain %0d energy %0d",
                         $time, dout.sample_out, dout.gate_gain, dout.window_energy);
                mismatches++;
            end
            else
            begin
                want = gated_results_due.pop_front();
                if (dout.sample_out !== want.sample_out)
                begin
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, want.sample_out, dout.sample_out);
                    mismatches++;
                end
                if (dout.gate_gain !== want.gate_gain)
                begin
                    $display("%0t: gate_gain expected %0d actual %0d",
                             $time, want.gate_gain, dout.gate_gain);
                    mismatches++;
                end
                if (dout.window_energy !== want.window_energy)
                begin
                    $display("%0t: window_energy expected %0d actual %0d",
                             $time, want.window_energy, dout.window_energy);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("rms_noise_gate_unit test failed");
        $finish;
    end

    initial
    begin : stimulus
        int random_items;
        int phase_items;
        int phase;
        int seg_len;
        int seg_kind;
        int amp;
        sample_t s;
        din.valid     = 1'b0;
        din.sample_in = '0;
        cfg.valid     = 1'b0;
        cfg.index     = '0;
        cfg.data      = '0;
        rst_n         = 1'b0;
        idling_on     = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        energy_thr    = THRESHOLD_RST;
        attack_inc    = ATTACK_RST;
        release_dec   = RELEASE_RST;
        makeup_lin    = MAKEUP_RST;
        slot_ptr      = '0;
        gain_now      = GAIN_ZERO;
        foreach (window_mem[i])
            window_mem[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idling_on = 1'b1;

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_WRITE)
            begin
                finish_requests();
                write_reg(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].data);
            end
            else
                send_sample(sample_t'(DIRECTED_ROWS[i].data), DIRECTED_ROWS[i].typed,
                            DIRECTED_ROWS[i].want);
        end

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            finish_requests();
            idling_on = (random_items < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            // A full window of negative full-scale samples drives the energy into
            // saturation, so that phase also puts the threshold right at the limit.
            write_reg(REG_THRESHOLD, (phase == 2) ? CFG_DATA_W'(ENERGY_MAX) : pick_threshold());
            write_reg(REG_ATTACK, pick_step());
            write_reg(REG_RELEASE, pick_step());
            write_reg(REG_MAKEUP, pick_makeup());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                          CFG_DATA_W'({$urandom, $urandom}));

            phase_items = 0;
            if (phase == 2)
            begin
                repeat (WINDOW_DEF + 8) send_sample(NEG_FULL, 1'b0, '0);
                phase_items = WINDOW_DEF + 8;
            end
            while (phase_items < PHASE_ITEMS)
            begin
                seg_len = $urandom_range(10, 120);
                seg_kind = $urandom_range(0, 4);
                amp = (seg_kind == 1) ? (1 << $urandom_range(0, 10)) : (1 << $urandom_range(11, 22));
                repeat (seg_len)
                begin
                    case (seg_kind)
                        0: s = '0;
                        3: s = sample_t'($urandom);
                        4: s = $urandom_range(0, 1) ? POS_FULL : NEG_FULL;
                        default: s = sample_t'(int'($urandom_range(0, 2 * amp - 1)) - amp);
                    endcase
                    send_sample(s, 1'b0, '0);
                end
                phase_items += seg_len;
            end
            random_items += phase_items;
            phase++;
        end

        finish_requests();
        if (mismatches == 0)
            $display("rms_noise_gate_unit test passed");
        else
            $display("rms_noise_gate_unit test failed");
        $finish;
    end

endmodule
